### hw/rtl/lbco_pkg.sv
`default_nettype none

package lbco_pkg;

    // Pixel and result field widths.
    localparam int PIXEL_W    = 8;
    localparam int LUMA_W     = 8;
    localparam int OFFSET_W   = 10;
    localparam int MATCH_W    = 21;

    // Configuration register widths.
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_PCT_W  = 7;
    localparam int CFG_TOL_W  = 8;

    // APB port sizes.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PERCENT      = 2'd2;
    localparam logic [1:0] REG_TOLERANCE    = 2'd3;

    // Register reset values.
    localparam logic [CFG_SIZE_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_SIZE_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;
    localparam logic [CFG_PCT_W-1:0]  RESET_PERCENT      = 7'd50;
    localparam logic [CFG_TOL_W-1:0]  RESET_TOLERANCE    = 8'd20;

    // Percent limits and the divisor of the target computation.
    localparam logic [CFG_PCT_W-1:0] PERCENT_MIN = 7'd1;
    localparam logic [CFG_PCT_W-1:0] PERCENT_MAX = 7'd100;
    localparam int                   PROD_W      = CFG_PCT_W + LUMA_W;

    // Luma weights: 0.299, 0.587 and 0.114 in 16-bit fixed point.
    localparam int              WEIGHT_W     = 16;
    localparam logic [15:0]     WEIGHT_RED   = 16'd19595;
    localparam logic [15:0]     WEIGHT_GREEN = 16'd38470;
    localparam logic [15:0]     WEIGHT_BLUE  = 16'd7471;
    localparam int              LUMA_SUM_W   = WEIGHT_W + PIXEL_W + 2;

    // Default image size limits.
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lbco_ram.sv
`default_nettype none

module lbco_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/luma_band_centroid_offset.sv
// Channel  | Ports                                              | Direction
// ---------+----------------------------------------------------+----------
// pixel    | s_valid, s_ready, s_red, s_green, s_blue,          | in
//          | s_last_pixel                                       |
// result   | m_valid, m_ready, m_center_x_offset,               | out
//          | m_center_y_offset, m_found, m_matched_count        |
// config   | psel, penable, pwrite, paddr, pwdata, prdata,      | in/out
//          | pready                                             |
//
// Luma of each pixel is computed at acceptance and the luma store is written
// in the next cycle, before the next pixel is accepted.
// After the last pixel the store is read once per pixel of the window, and a
// bit-serial divider (DIV_W steps) is shared by the target computation and
// the two mean divisions.
// Reset is synchronous and active low; the luma store is not cleared.
// A finished result waits in the output register while new pixels load;
// a second result waits for it to be taken.
`default_nettype none

module luma_band_centroid_offset
    import lbco_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [PIXEL_W-1:0]          s_red,
    input  wire logic [PIXEL_W-1:0]          s_green,
    input  wire logic [PIXEL_W-1:0]          s_blue,
    input  wire logic                        s_last_pixel,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [OFFSET_W-1:0]       m_center_x_offset,
    output logic signed [OFFSET_W-1:0]       m_center_y_offset,
    output logic                             m_found,
    output logic        [MATCH_W-1:0]        m_matched_count,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [APB_ADDR_W-1:0]       paddr,
    input  wire logic [APB_DATA_W-1:0]       pwdata,
    output logic      [APB_DATA_W-1:0]       prdata,
    output logic                             pready
);

    // Derived sizes.
    localparam int PIX_N  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(PIX_N);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int EXT_W  = max_int(CFG_SIZE_W, max_int(CW, RW) + 1);
    localparam int CNT_W  = $clog2(PIX_N + 1);
    localparam int CSUM_W = CW + CNT_W;
    localparam int RSUM_W = RW + CNT_W;
    localparam int DIV_W  = max_int(PROD_W, max_int(CSUM_W, RSUM_W));
    localparam int DEN_W  = max_int(CNT_W, CFG_PCT_W);
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRITE  = 4'd1;
    localparam logic [3:0] S_PROD   = 4'd2;
    localparam logic [3:0] S_TDIV   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_XDIV   = 4'd7;
    localparam logic [3:0] S_YDIV   = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] state_reg, state_next;

    // Configuration registers.
    logic [CFG_SIZE_W-1:0] cfg_width_reg;
    logic [CFG_SIZE_W-1:0] cfg_height_reg;
    logic [CFG_PCT_W-1:0]  cfg_pct_reg;
    logic [CFG_TOL_W-1:0]  cfg_tol_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RESET_IMAGE_WIDTH;
            cfg_height_reg <= RESET_IMAGE_HEIGHT;
            cfg_pct_reg    <= RESET_PERCENT;
            cfg_tol_reg    <= RESET_TOLERANCE;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  cfg_width_reg  <= pwdata[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_PERCENT:      cfg_pct_reg    <= pwdata[CFG_PCT_W-1:0];
                REG_TOLERANCE:    cfg_tol_reg    <= pwdata[CFG_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_height_reg);
            REG_PERCENT:      prdata = APB_DATA_W'(cfg_pct_reg);
            REG_TOLERANCE:    prdata = APB_DATA_W'(cfg_tol_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective image size and percent, saturated into their legal ranges.
    logic [EXT_W-1:0]     w_eff, h_eff;
    logic [CFG_PCT_W-1:0] pct_eff;

    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = EXT_W'(1);
        end else if (EXT_W'(cfg_width_reg) > EXT_W'(MAX_WIDTH)) begin
            w_eff = EXT_W'(MAX_WIDTH);
        end else begin
            w_eff = EXT_W'(cfg_width_reg);
        end
        if (cfg_height_reg == '0) begin
            h_eff = EXT_W'(1);
        end else if (EXT_W'(cfg_height_reg) > EXT_W'(MAX_HEIGHT)) begin
            h_eff = EXT_W'(MAX_HEIGHT);
        end else begin
            h_eff = EXT_W'(cfg_height_reg);
        end
        if (cfg_pct_reg < PERCENT_MIN) begin
            pct_eff = PERCENT_MIN;
        end else if (cfg_pct_reg > PERCENT_MAX) begin
            pct_eff = PERCENT_MAX;
        end else begin
            pct_eff = cfg_pct_reg;
        end
    end

    // Luma of the incoming pixel, computed at acceptance.
    logic [LUMA_SUM_W-1:0] luma_sum;
    logic [LUMA_W-1:0]     luma_reg;
    logic                  last_reg;
    logic                  s_take;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_take   = s_valid && s_ready;
    assign luma_sum = LUMA_SUM_W'(WEIGHT_RED * s_red)
                    + LUMA_SUM_W'(WEIGHT_GREEN * s_green)
                    + LUMA_SUM_W'(WEIGHT_BLUE * s_blue);

    always_ff @(posedge aclk) begin
        if (s_take) begin
            luma_reg <= luma_sum[WEIGHT_W +: LUMA_W];
            last_reg <= s_last_pixel;
        end
    end

    // Load position with wrap at the end of a row and after the last row.
    logic [CW-1:0] load_col_reg, load_col_next;
    logic [RW-1:0] load_row_reg, load_row_next;
    logic [AW-1:0] load_base_reg, load_base_next;
    logic [CW-1:0] col_b;
    logic [RW:0]   row_a;
    logic [RW-1:0] row_b;
    logic [AW-1:0] base_a, base_b;
    logic [CW:0]   col_c;
    logic [RW:0]   row_c;
    logic [AW-1:0] wr_addr;

    always_comb begin
        // A size reduced since the last pixel may put the position outside.
        if (EXT_W'(load_col_reg) >= w_eff) begin
            col_b  = '0;
            row_a  = (RW + 1)'(load_row_reg) + 1'b1;
            base_a = AW'(load_base_reg + AW'(MAX_WIDTH));
        end else begin
            col_b  = load_col_reg;
            row_a  = (RW + 1)'(load_row_reg);
            base_a = load_base_reg;
        end
        if (EXT_W'(row_a) >= h_eff) begin
            row_b  = '0;
            base_b = '0;
        end else begin
            row_b  = RW'(row_a);
            base_b = base_a;
        end
        wr_addr = base_b + AW'(col_b);

        // Advance past the pixel just written.
        col_c = (CW + 1)'(col_b) + 1'b1;
        row_c = (RW + 1)'(row_b) + 1'b1;
        if (EXT_W'(col_c) >= w_eff) begin
            load_col_next = '0;
            if (EXT_W'(row_c) >= h_eff) begin
                load_row_next  = '0;
                load_base_next = '0;
            end else begin
                load_row_next  = RW'(row_c);
                load_base_next = AW'(base_b + AW'(MAX_WIDTH));
            end
        end else begin
            load_col_next  = CW'(col_c);
            load_row_next  = row_b;
            load_base_next = base_b;
        end
    end

    // Darkest and brightest luma of the image and the load position.
    logic [LUMA_W-1:0] dark_reg, bright_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg      <= '1;
            bright_reg    <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            load_base_reg <= '0;
        end else if (state_reg == S_WRITE) begin
            if (luma_reg < dark_reg) begin
                dark_reg <= luma_reg;
            end
            if (luma_reg > bright_reg) begin
                bright_reg <= luma_reg;
            end
            load_col_reg  <= load_col_next;
            load_row_reg  <= load_row_next;
            load_base_reg <= load_base_next;
        end else if (state_reg == S_FINISH && (!m_valid || m_ready)) begin
            dark_reg      <= '1;
            bright_reg    <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            load_base_reg <= '0;
        end
    end

    // Scan counters over the window.
    logic [CW-1:0]     scan_col_reg;
    logic [RW-1:0]     scan_row_reg;
    logic [AW-1:0]     scan_base_reg;
    logic [AW-1:0]     rd_addr;
    logic [LUMA_W-1:0] rd_data;
    logic              scan_col_last, scan_row_last;

    assign rd_addr       = scan_base_reg + AW'(scan_col_reg);
    assign scan_col_last = (EXT_W'(scan_col_reg) == w_eff - 1'b1);
    assign scan_row_last = (EXT_W'(scan_row_reg) == h_eff - 1'b1);

    lbco_ram #(
        .DATA_W (LUMA_W),
        .DEPTH  (PIX_N)
    ) u_luma_store (
        .aclk    (aclk),
        .wr_en   (state_reg == S_WRITE),
        .wr_addr (wr_addr),
        .wr_data (luma_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == S_TDIV) begin
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            scan_base_reg <= '0;
        end else if (state_reg == S_SCAN) begin
            if (scan_col_last) begin
                scan_col_reg  <= '0;
                scan_row_reg  <= scan_row_reg + 1'b1;
                scan_base_reg <= AW'(scan_base_reg + AW'(MAX_WIDTH));
            end else begin
                scan_col_reg <= scan_col_reg + 1'b1;
            end
        end
    end

    // Position of the read in flight, aligned with the registered data.
    logic          pipe_valid_reg;
    logic [CW-1:0] pipe_col_reg;
    logic [RW-1:0] pipe_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else begin
            pipe_valid_reg <= (state_reg == S_SCAN);
        end
        pipe_col_reg <= scan_col_reg;
        pipe_row_reg <= scan_row_reg;
    end

    // Band test and accumulation.
    logic [LUMA_W-1:0] target_reg;
    logic [LUMA_W-1:0] luma_dist;
    logic              in_band;
    logic [CNT_W-1:0]  count_reg;
    logic [CSUM_W-1:0] col_sum_reg;
    logic [RSUM_W-1:0] row_sum_reg;

    assign luma_dist = (rd_data > target_reg) ? (rd_data - target_reg)
                                              : (target_reg - rd_data);
    assign in_band   = (luma_dist <= cfg_tol_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == S_TDIV) begin
            count_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end else if (pipe_valid_reg && in_band) begin
            count_reg   <= count_reg + 1'b1;
            col_sum_reg <= col_sum_reg + CSUM_W'(pipe_col_reg);
            row_sum_reg <= row_sum_reg + RSUM_W'(pipe_row_reg);
        end
    end

    // Shared restoring divider: one quotient bit per cycle.
    logic [DIV_W-1:0]  div_quo_reg;
    logic [DEN_W-1:0]  div_rem_reg;
    logic [DEN_W-1:0]  div_den_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_load;
    logic [DIV_W-1:0]  div_num_in;
    logic [DEN_W-1:0]  div_den_in;
    logic [DEN_W:0]    div_shift;
    logic              div_fits;
    logic              div_done;

    assign div_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_fits  = (div_shift >= (DEN_W + 1)'(div_den_reg));
    assign div_done  = (div_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (div_load) begin
            div_quo_reg <= div_num_in;
            div_rem_reg <= '0;
            div_den_reg <= div_den_in;
            div_cnt_reg <= DCNT_W'(DIV_W);
        end else if (!div_done) begin
            div_rem_reg <= div_fits ? DEN_W'(div_shift - (DEN_W + 1)'(div_den_reg))
                                    : DEN_W'(div_shift);
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_fits};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // Spread between brightest and darkest times the percent.
    logic [PROD_W-1:0] span_prod;
    assign span_prod = PROD_W'(pct_eff * (bright_reg - dark_reg));

    // Sequencer.
    logic [DIV_W-1:0] quo_x_reg;

    always_comb begin
        state_next = state_reg;
        div_load   = 1'b0;
        div_num_in = '0;
        div_den_in = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = last_reg ? S_PROD : S_IDLE;
            end
            S_PROD: begin
                div_load   = 1'b1;
                div_num_in = DIV_W'(span_prod);
                div_den_in = DEN_W'(PERCENT_MAX);
                state_next = S_TDIV;
            end
            S_TDIV: begin
                if (div_done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_col_last && scan_row_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (count_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    div_load   = 1'b1;
                    div_num_in = DIV_W'(col_sum_reg);
                    div_den_in = DEN_W'(count_reg);
                    state_next = S_XDIV;
                end
            end
            S_XDIV: begin
                if (div_done) begin
                    div_load   = 1'b1;
                    div_num_in = DIV_W'(row_sum_reg);
                    div_den_in = DEN_W'(count_reg);
                    state_next = S_YDIV;
                end
            end
            S_YDIV: begin
                if (div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Target luma and the column quotient.
    always_ff @(posedge aclk) begin
        if (state_reg == S_TDIV && div_done) begin
            target_reg <= dark_reg + LUMA_W'(div_quo_reg);
        end
        if (state_reg == S_XDIV && div_done) begin
            quo_x_reg <= div_quo_reg;
        end
    end

    // Result register; it holds until the request is taken.
    logic result_load;
    logic found;

    assign result_load = (state_reg == S_FINISH) && (!m_valid || m_ready);
    assign found       = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (result_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_found         <= found;
            m_matched_count <= MATCH_W'(count_reg);
            if (found) begin
                m_center_x_offset <= OFFSET_W'(quo_x_reg) - OFFSET_W'(w_eff >> 1);
                m_center_y_offset <= OFFSET_W'(div_quo_reg) - OFFSET_W'(h_eff >> 1);
            end else begin
                m_center_x_offset <= '0;
                m_center_y_offset <= '0;
            end
        end
    end

endmodule

`default_nettype wire
